// File: rtl/rsput_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsput_pkg: shared types and constants of the range sum tree
// Field widths, operation codes and the command / status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package rsput_pkg;

   // field widths
   localparam int POS_W      = 11;
   localparam int SUM_W      = 32;
   localparam int REQ_DATA_W = 56;

   // parameter defaults and register reset
   localparam int               DEFAULT_MAX_ELEMENTS = 1024;
   localparam logic [POS_W-1:0] ELEMENTS_RESET       = 11'd1024;

   // operation codes carried in req_tuser
   localparam logic FUNC_QUERY  = 1'b0;
   localparam logic FUNC_UPDATE = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic load;      // latch a new request beat, start at the root
      logic clr_step;  // write zero at the clear address, advance it
      logic u_desc;    // step one level down toward the update leaf
      logic u_leaf;    // write the leaf, fetch its sibling
      logic u_asc;     // write one parent sum, fetch the next sibling
      logic q_step;    // visit one node of the query walk
      logic q_finish;  // load the response register
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic req_skip;     // request beat has no work (empty range, bad position)
      logic at_leaf;      // current node covers one element
      logic at_root;      // current node is the root
      logic parent_root;  // parent of the current node is the root
      logic walk_last;    // this query step ends the walk
      logic clear_last;   // clear address is on the last entry
   } dp_status_type;

endpackage

// File: rtl/rsput_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsput_ram: generic simple dual-port ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rsput_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/rsput_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsput_dp: range sum tree datapath
// Node cursor, pending-node stack, accumulator, clear sweep and the node ram.
// ----------------------------------------------------------------------------
module rsput_dp
   import rsput_pkg::*;
#(
   parameter int MAX_ELEMENTS = DEFAULT_MAX_ELEMENTS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_func,
   input  logic [POS_W-1:0]        req_left,
   input  logic [POS_W-1:0]        req_right,
   input  logic signed [SUM_W-1:0] req_value,
   input  logic                    csr_wr_en,
   input  logic [POS_W-1:0]        csr_wr_data,
   input  dp_cmd_type              cmd,
   output dp_status_type           status,
   output logic signed [SUM_W-1:0] rsp_data
);

   localparam int NODE_W = $clog2(MAX_ELEMENTS) + 1;
   localparam int DEPTH  = 1 << NODE_W;
   localparam int STK_D  = NODE_W;
   localparam int SP_W   = $clog2(STK_D + 1);
   localparam int IDX_W  = $clog2(STK_D);

   // element count register
   logic [POS_W-1:0] count_ff;
   logic [POS_W-1:0] n_eff;

   // walk state
   logic [NODE_W-1:0]       node_ff, node_in;
   logic [POS_W-1:0]        lo_ff, lo_in, hi_ff, hi_in;
   logic [POS_W-1:0]        a_ff, a_in, b_ff, b_in;
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic                    rd_pend_ff, rd_pend_in;
   logic [SP_W-1:0]         sp_ff, sp_in;
   logic [NODE_W-1:0]       clr_addr_ff;
   logic signed [SUM_W-1:0] rsp_data_ff;

   // pending right children of the query walk
   logic [NODE_W-1:0] stk_node_ff [STK_D];
   logic [POS_W-1:0]  stk_lo_ff   [STK_D];
   logic [POS_W-1:0]  stk_hi_ff   [STK_D];
   logic              push;
   logic [NODE_W-1:0] push_node;
   logic [POS_W-1:0]  push_lo;
   logic [IDX_W-1:0]  push_idx, top_idx;

   // ram ports
   logic                    ram_we, ram_re;
   logic [NODE_W-1:0]       ram_waddr, ram_raddr;
   logic signed [SUM_W-1:0] ram_wdata, ram_rdata;

   // node geometry
   logic [POS_W:0]          lo_hi_sum;
   logic [POS_W-1:0]        mid;
   logic                    covered, disjoint, partial, go_left, go_right;
   logic [NODE_W-1:0]       node_l, node_r, parent;
   logic signed [SUM_W-1:0] sum_up, acc_plus;

   assign n_eff = (32'(count_ff) > 32'(MAX_ELEMENTS)) ? POS_W'(MAX_ELEMENTS) : count_ff;

   assign lo_hi_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = lo_hi_sum[POS_W:1];
   assign covered   = (lo_ff >= a_ff) && (hi_ff <= b_ff);
   assign disjoint  = (lo_ff > b_ff) || (hi_ff < a_ff);
   assign partial   = !covered && !disjoint;
   assign go_left   = a_ff <= mid;
   assign go_right  = b_ff > mid;
   assign node_l    = {node_ff[NODE_W-2:0], 1'b0};
   assign node_r    = {node_ff[NODE_W-2:0], 1'b1};
   assign parent    = node_ff >> 1;
   assign sum_up    = acc_ff + ram_rdata;
   assign acc_plus  = rd_pend_ff ? sum_up : acc_ff;
   assign push_idx  = sp_ff[IDX_W-1:0];
   assign top_idx   = IDX_W'(sp_ff - SP_W'(1));

   // status toward the controller
   always_comb begin
      status = '0;
      if (req_func == FUNC_UPDATE) begin
         status.req_skip = (n_eff == '0) || (req_left == '0) || (req_left > n_eff);
      end else begin
         status.req_skip = (n_eff == '0) || (req_left > req_right);
      end
      status.at_leaf     = lo_ff == hi_ff;
      status.at_root     = node_ff == NODE_W'(1);
      status.parent_root = parent == NODE_W'(1);
      status.walk_last   = !partial && (sp_ff == '0);
      status.clear_last  = &clr_addr_ff;
   end

   // next walk state and ram access
   always_comb begin
      node_in    = node_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      acc_in     = acc_ff;
      rd_pend_in = rd_pend_ff;
      sp_in      = sp_ff;
      push       = 1'b0;
      push_node  = node_r;
      push_lo    = mid + POS_W'(1);
      ram_we     = 1'b0;
      ram_waddr  = node_ff;
      ram_wdata  = acc_ff;
      ram_re     = 1'b0;
      ram_raddr  = node_ff;

      if (cmd.load) begin
         node_in    = NODE_W'(1);
         lo_in      = POS_W'(1);
         hi_in      = n_eff;
         a_in       = req_left;
         b_in       = req_right;
         acc_in     = (req_func == FUNC_UPDATE) ? req_value : '0;
         rd_pend_in = 1'b0;
         sp_in      = '0;
      end

      if (cmd.clr_step) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = '0;
      end

      // descend toward the update position
      if (cmd.u_desc) begin
         if (go_left) begin
            node_in = node_l;
            hi_in   = mid;
         end else begin
            node_in = node_r;
            lo_in   = mid + POS_W'(1);
         end
      end

      // write the leaf and fetch its sibling
      if (cmd.u_leaf) begin
         ram_we    = 1'b1;
         ram_waddr = node_ff;
         ram_wdata = acc_ff;
         ram_re    = 1'b1;
         ram_raddr = node_ff ^ NODE_W'(1);
      end

      // fold the sibling into the parent, fetch the parent's sibling
      if (cmd.u_asc) begin
         ram_we    = 1'b1;
         ram_waddr = parent;
         ram_wdata = sum_up;
         ram_re    = 1'b1;
         ram_raddr = parent ^ NODE_W'(1);
         acc_in    = sum_up;
         node_in   = parent;
      end

      // one node of the query walk
      if (cmd.q_step) begin
         acc_in     = acc_plus;
         rd_pend_in = covered;
         if (covered) begin
            ram_re    = 1'b1;
            ram_raddr = node_ff;
         end
         if (partial) begin
            if (go_left) begin
               node_in = node_l;
               hi_in   = mid;
               if (go_right) begin
                  push  = 1'b1;
                  sp_in = sp_ff + SP_W'(1);
               end
            end else begin
               node_in = node_r;
               lo_in   = mid + POS_W'(1);
            end
         end else if (sp_ff != '0) begin
            node_in = stk_node_ff[top_idx];
            lo_in   = stk_lo_ff[top_idx];
            hi_in   = stk_hi_ff[top_idx];
            sp_in   = sp_ff - SP_W'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= ELEMENTS_RESET;
         clr_addr_ff <= '0;
         sp_ff       <= '0;
         rd_pend_ff  <= 1'b0;
      end else begin
         sp_ff      <= sp_in;
         rd_pend_ff <= rd_pend_in;
         if (csr_wr_en) begin
            count_ff    <= csr_wr_data;
            clr_addr_ff <= '0;
         end else if (cmd.clr_step) begin
            clr_addr_ff <= clr_addr_ff + NODE_W'(1);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      node_ff <= node_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      if (push) begin
         stk_node_ff[push_idx] <= push_node;
         stk_lo_ff[push_idx]   <= push_lo;
         stk_hi_ff[push_idx]   <= hi_ff;
      end
      if (cmd.q_finish) begin
         rsp_data_ff <= acc_plus;
      end
   end

   assign rsp_data = rsp_data_ff;

   // node sums
   rsput_ram #(
      .WIDTH (SUM_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // stack never runs past one entry per tree level
   assert property (@(posedge clock) disable iff (reset) 32'(sp_ff) < STK_D)
      else $error("pending-node stack overflow");

   // the update descent never starts below a leaf
   assert property (@(posedge clock) disable iff (reset) cmd.u_desc |-> (lo_ff != hi_ff))
      else $error("update descent from a leaf");

   // a query walk never writes the tree
   assert property (@(posedge clock) disable iff (reset) cmd.q_step |-> !ram_we)
      else $error("tree written during a query");

endmodule

// File: rtl/rsput_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsput_ctrl: range sum tree controller
// Sequences the clear sweep, update descent and ascent, the query walk, and
// owns the response valid flag.
// ----------------------------------------------------------------------------
module rsput_ctrl
   import rsput_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          req_func,
   input  logic          csr_wr_en,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_UDESC = 3'd2;
   localparam logic [2:0] S_UASC  = 3'd3;
   localparam logic [2:0] S_QWALK = 3'd4;
   localparam logic [2:0] S_QDONE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (status.req_skip) begin
                  state_in = (req_func == FUNC_UPDATE) ? S_IDLE : S_QDONE;
               end else begin
                  state_in = (req_func == FUNC_UPDATE) ? S_UDESC : S_QWALK;
               end
            end
         end
         S_UDESC: begin
            if (status.at_leaf) begin
               cmd.u_leaf = 1'b1;
               state_in   = status.at_root ? S_IDLE : S_UASC;
            end else begin
               cmd.u_desc = 1'b1;
            end
         end
         S_UASC: begin
            cmd.u_asc = 1'b1;
            if (status.parent_root) begin
               state_in = S_IDLE;
            end
         end
         S_QWALK: begin
            cmd.q_step = 1'b1;
            if (status.walk_last) begin
               state_in = S_QDONE;
            end
         end
         S_QDONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.q_finish = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
      // a new element count reshapes the tree
      if (csr_wr_en) begin
         state_in = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // every register write is followed by a clear sweep
   assert property (@(posedge clock) disable iff (reset) csr_wr_en |=> (state_ff == S_CLEAR))
      else $error("register write without clear sweep");

   // the response register is loaded only when free or being taken
   assert property (@(posedge clock) disable iff (reset)
      cmd.q_finish |-> (!rsp_valid_ff || rsp_tready))
      else $error("response overwritten");

   // the update ascent never raises a response
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UASC) |=> !$rose(rsp_valid_ff))
      else $error("response raised by an update");

endmodule

// File: rtl/range_sum_point_update_tree_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_sum_point_update_tree_top: range sum / point update tree
// Binary tree of wrapping 32-bit partial sums over a 1-based element array.
// ----------------------------------------------------------------------------
// Usage:
//   req beats carry one operation: tuser = 0 asks for the sum of elements
//   left..right (clipped to 1..n, 0 when empty), tuser = 1 sets element left
//   to value and gives no response. rsp beats return one sum per query.
//   csr_wr_en loads n (elements in use); values above MAX_ELEMENTS act as
//   MAX_ELEMENTS. Write it only while the block is idle.
// Timing:
//   one item at a time; req_tready is high only in idle. With leaves at depth
//   D (10 for 1024 elements) an update steps down one level at a time, writes
//   the leaf while reading its sibling, then climbs one level at a time,
//   writing each parent sum through the ram while reading the next sibling.
//   A query walk visits its nodes one at a time through the single ram read port.
// Reset and clear:
//   reset, and every csr write, start a clear sweep that zeroes all
//   2^(clog2(MAX_ELEMENTS)+1) node ram entries, 2048 by default, one entry a cycle.
//   No request is taken during the sweep.
// Stall:
//   a response waits in an output register; the next request is taken while
//   it waits, and a later query holds its result until the register is free.
// ----------------------------------------------------------------------------
module range_sum_point_update_tree_top
   import rsput_pkg::*;
#(
   parameter int MAX_ELEMENTS = DEFAULT_MAX_ELEMENTS
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // left[10:0], right[21:11], value[53:22], zero pad
   input  logic                  req_tuser,   // func
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SUM_W-1:0]      rsp_tdata,   // range_sum[31:0]
   // configuration
   input  logic                  csr_wr_en,
   input  logic [POS_W-1:0]      csr_wr_data  // elements_in_use
);

   dp_cmd_type              cmd;
   dp_status_type           status;
   logic signed [SUM_W-1:0] rsp_sum;

   // request unpacking
   logic [POS_W-1:0]        req_left, req_right;
   logic signed [SUM_W-1:0] req_value;

   assign req_left  = req_tdata[POS_W-1:0];
   assign req_right = req_tdata[2*POS_W-1:POS_W];
   assign req_value = req_tdata[2*POS_W+SUM_W-1:2*POS_W];
   assign rsp_tdata = rsp_sum;

   rsput_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .csr_wr_en  (csr_wr_en),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rsput_dp #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_func    (req_tuser),
      .req_left    (req_left),
      .req_right   (req_right),
      .req_value   (req_value),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_data    (rsp_sum)
   );

endmodule

// File: bench/range_sum_point_update_tree_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_sum_point_update_tree_top_test: self-checking bench for the range sum tree
// Drives update and query beats into the tree under bursty request traffic and
// a stalling response side. An element-array model predicts every range sum.
// Each response beat is checked against the oldest predicted sum. Directed
// tests cover the field extremes, the empty and clipped ranges, out-of-range
// updates and the zero and oversized element counts. Random phases then run
// at several element counts.
// ----------------------------------------------------------------------------
module range_sum_point_update_tree_top_test;
   import rsput_pkg::*;

   localparam int          MAX_ELEMENTS  = DEFAULT_MAX_ELEMENTS;
   localparam int          SETTLE_CYCLES = 64;      // above the longest query walk
   localparam int unsigned CYCLE_LIMIT   = 400000;

   // dut ports
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;   // left[10:0], right[21:11], value[53:22], pad
   logic                  req_tuser   = FUNC_QUERY;  // func
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [SUM_W-1:0]      rsp_tdata;           // range_sum[31:0]
   logic                  csr_wr_en   = 1'b0;
   logic [POS_W-1:0]      csr_wr_data = '0;

   // element-array model of the tree and the sums still owed by the dut
   logic [SUM_W-1:0] element_vals [1:MAX_ELEMENTS];
   int unsigned      active_count = MAX_ELEMENTS;
   logic [SUM_W-1:0] pending_sums [$];

   // run bookkeeping
   int unsigned error_count  = 0;
   int unsigned sums_checked = 0;
   int unsigned update_beats = 0;
   int unsigned query_beats  = 0;
   int unsigned size_writes  = 0;
   int unsigned burst_left   = 0;
   int unsigned cycle_count  = 0;

   range_sum_point_update_tree_top #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d sums outstanding", $time, pending_sums.size());
         $display("range_sum_point_update_tree_top verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // model
   // ---------------------------------------------------------------------------

   function automatic bit position_in_use(input logic [POS_W-1:0] pos);
      return pos >= 1 && pos <= active_count;
   endfunction

   // sum of elements left..right clipped to 1..n, wrapping at 32 bits
   function automatic logic [SUM_W-1:0] clipped_range_sum(input logic [POS_W-1:0] left,
                                                          input logic [POS_W-1:0] right);
      int unsigned      lo;
      int unsigned      hi;
      logic [SUM_W-1:0] acc;
      acc = '0;
      if (active_count == 0 || left > right)
         return acc;
      lo = (left < 1) ? 1 : 32'(left);
      hi = (32'(right) > active_count) ? active_count : 32'(right);
      for (int unsigned i = lo; i <= hi; i++)
         acc = acc + element_vals[i];
      return acc;
   endfunction

   function automatic void clear_elements();
      for (int i = 1; i <= MAX_ELEMENTS; i++)
         element_vals[i] = '0;
   endfunction

   // ---------------------------------------------------------------------------
   // response side: stall pattern and checker
   // ---------------------------------------------------------------------------

   logic [31:0] stall_pattern = '1;
   logic [4:0]  stall_phase   = '0;

   always @(negedge clock) begin
      if (stall_phase == 0) begin
         case ($urandom_range(0, 3))
            0:       stall_pattern = '1;                     // no stalls at all
            1, 2:    stall_pattern = $urandom | $urandom;    // light stalls
            default: stall_pattern = $urandom & $urandom;    // heavy stalls
         endcase
      end
      rsp_tready <= reset ? 1'b0 : stall_pattern[stall_phase];
      stall_phase = stall_phase + 1'b1;
   end

   // compare each response beat with the oldest predicted sum
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_sums.size() == 0) begin
            $display("%0t: unexpected response beat, expected none, actual %h",
                     $time, rsp_tdata);
            error_count++;
         end else begin
            if (rsp_tdata !== pending_sums[0]) begin
               $display("%0t: range_sum mismatch, expected %h, actual %h",
                        $time, pending_sums[0], rsp_tdata);
               error_count++;
            end
            void'(pending_sums.pop_front());
            sums_checked++;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------

   // one request beat, preceded by a random gap at the end of each burst;
   // called and returns at a falling edge with tvalid left high
   task automatic send_item(input logic func, input logic [POS_W-1:0] left,
                            input logic [POS_W-1:0] right, input logic [SUM_W-1:0] value);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 20);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {2'b00, value, right, left};
      do @(posedge clock); while (!req_tready);
      // beat accepted, advance the model
      if (func == FUNC_UPDATE) begin
         update_beats++;
         if (position_in_use(left))
            element_vals[left] = value;
      end else begin
         query_beats++;
         pending_sums.push_back(clipped_range_sum(left, right));
      end
      @(negedge clock);
   endtask

   // drop tvalid, let every owed sum arrive, then wait for the block to go idle
   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (pending_sums.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      while (!req_tready) @(negedge clock);
   endtask

   // element count write; the dut clears its tree, so the model does too
   task automatic write_element_count(input logic [POS_W-1:0] count);
      wait_for_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count;
      @(negedge clock);
      csr_wr_en    <= 1'b0;
      active_count  = (32'(count) > MAX_ELEMENTS) ? MAX_ELEMENTS : 32'(count);
      size_writes++;
      clear_elements();
   endtask

   function automatic logic [SUM_W-1:0] random_value();
      case ($urandom_range(0, 5))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'($signed($urandom_range(0, 16)) - 8);
         default: return $urandom;
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // reset size of 1024: extremes of every field, clipping and ignored updates
   task automatic test_reset_size();
      wait_for_idle();
      send_item(FUNC_UPDATE, 11'd1,    11'd0,    32'h7FFF_FFFF);
      send_item(FUNC_UPDATE, 11'd1024, 11'h7FF,  32'h8000_0000);
      send_item(FUNC_UPDATE, 11'd512,  11'd3,    32'hFFFF_FFFF);
      send_item(FUNC_UPDATE, 11'd0,    11'd0,    32'h1234_5678);  // position zero
      send_item(FUNC_UPDATE, 11'd1025, 11'd1,    32'hFFFF_FFFF);  // beyond n
      send_item(FUNC_UPDATE, 11'h7FF,  11'h7FF,  32'hFFFF_FFFF);  // all ones
      send_item(FUNC_QUERY,  11'd1,    11'd1024, 32'hFFFF_FFFF);  // wraps
      send_item(FUNC_QUERY,  11'd0,    11'h7FF,  32'h0);          // clipped both ends
      send_item(FUNC_QUERY,  11'd1024, 11'd1,    32'h0);          // left above right
      send_item(FUNC_QUERY,  11'd1,    11'd1,    32'h0);
      send_item(FUNC_QUERY,  11'd1024, 11'd1024, 32'h0);
      send_item(FUNC_QUERY,  11'd1025, 11'h7FF,  32'h0);          // no overlap
      send_item(FUNC_QUERY,  11'd2,    11'd1023, 32'h0);
   endtask

   // a single element
   task automatic test_single_element();
      write_element_count(11'd1);
      send_item(FUNC_UPDATE, 11'd1, 11'd0, 32'h8000_0001);
      send_item(FUNC_UPDATE, 11'd2, 11'd0, 32'h0000_0005);        // beyond n
      send_item(FUNC_QUERY,  11'd1, 11'd1, 32'h0);
      send_item(FUNC_QUERY,  11'd0, 11'd5, 32'h0);
      send_item(FUNC_QUERY,  11'd2, 11'd2, 32'h0);
   endtask

   // zero elements: nothing is stored, every sum is zero
   task automatic test_zero_elements();
      write_element_count(11'd0);
      send_item(FUNC_UPDATE, 11'd1, 11'd1,   32'h0000_0042);
      send_item(FUNC_QUERY,  11'd1, 11'd1,   32'h0);
      send_item(FUNC_QUERY,  11'd0, 11'h7FF, 32'h0);
   endtask

   // count above the maximum acts as the maximum
   task automatic test_oversized_count();
      write_element_count(11'h7FF);
      send_item(FUNC_UPDATE, 11'd1024, 11'd0,   32'h0000_0007);
      send_item(FUNC_UPDATE, 11'd1025, 11'd0,   32'h0000_0009);   // still beyond n
      send_item(FUNC_QUERY,  11'd1000, 11'h7FF, 32'h0);
   endtask

   // random traffic at one element count, mostly well-formed beats
   task automatic test_random_traffic(input logic [POS_W-1:0] count, input int unsigned goal);
      int unsigned      done;
      int unsigned      reach;
      bit               paused;
      logic             func;
      logic [POS_W-1:0] left;
      logic [POS_W-1:0] right;
      logic [SUM_W-1:0] value;
      write_element_count(count);
      done   = 0;
      paused = 0;
      while (done < goal) begin
         if ($urandom_range(0, 9) < 2) begin
            // noise: any field pattern at all
            func  = 1'($urandom_range(0, 1));
            left  = POS_W'($urandom);
            right = POS_W'($urandom);
            value = $urandom;
         end else if ($urandom_range(0, 1) == 0) begin
            func  = FUNC_UPDATE;
            left  = POS_W'($urandom_range(1, active_count));
            right = POS_W'($urandom);
            value = random_value();
         end else begin
            func  = FUNC_QUERY;
            left  = POS_W'($urandom_range(1, active_count));
            if ($urandom_range(0, 2) == 0) begin
               reach = 32'(left) + $urandom_range(0, 3);
               right = POS_W'((reach > active_count) ? active_count : reach);
            end else begin
               right = POS_W'($urandom_range(32'(left), active_count));
            end
            value = $urandom;
         end
         send_item(func, left, right, value);
         if (func == FUNC_QUERY || position_in_use(left))
            done++;
         // drain everything once, mid-phase
         if (!paused && done >= goal / 2) begin
            paused = 1;
            wait_for_idle();
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------

   initial begin
      clear_elements();
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      test_reset_size();
      test_single_element();
      test_zero_elements();
      test_oversized_count();
      test_random_traffic(11'd2, 50);
      test_random_traffic(11'd9, 80);
      test_random_traffic(11'd64, 90);
      test_random_traffic(11'd300, 90);
      test_random_traffic(11'd1024, 90);
      test_random_traffic(POS_W'($urandom_range(3, 1023)), 90);

      wait_for_idle();
      $display("covered %0d update beats and %0d query beats over %0d element counts",
               update_beats, query_beats, size_writes + 1);
      $display("compared %0d range sums, %0d mismatches", sums_checked, error_count);
      if (error_count == 0)
         $display("range_sum_point_update_tree_top verification clean");
      else
         $display("range_sum_point_update_tree_top verification failed");
      $finish;
   end

endmodule
